### rtl/core/clcd_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface package
// Shared widths, command and register codes, job and configuration types.
// ----------------------------------------------------------------------------
package clcd_pkg;

   localparam int NUM_DIGITS = 6;

   localparam int CMD_W      = 3;
   localparam int CHAR_W     = 8;
   localparam int NUM_W      = 21;
   localparam int NIB_W      = 4;
   localparam int PULSE_W    = 8;
   localparam int WAIT_W     = 16;
   localparam int HOLD_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int CONV_CNT_W = $clog2(NUM_W + 1);

   localparam int JOB_FIFO_DEPTH = 4;
   localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);
   localparam int JOB_CNT_W      = $clog2(JOB_FIFO_DEPTH + 1);

   function automatic longint digit_limit(input int n);
      longint r;
      r = 1;
      for (int i = 0; i < n; i++) begin
         r = r * 10;
      end
      return r - 1;
   endfunction

   localparam longint NUM_LIMIT = digit_limit(NUM_DIGITS);

   localparam logic [CMD_W-1:0] CMD_DATA   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NUMBER = 3'd2;
   localparam logic [CMD_W-1:0] CMD_INIT   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_STRING = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POWERUP = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP     = 8'd3;

   localparam logic [PULSE_W-1:0] PULSE_RESET   = 8'd50;
   localparam logic [WAIT_W-1:0]  CLEAR_RESET   = 16'd1650;
   localparam logic [WAIT_W-1:0]  POWERUP_RESET = 16'd20000;
   localparam logic [WAIT_W-1:0]  GAP_RESET     = 16'd10000;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CLEAR_CODE = 8'h01;

   localparam logic [NIB_W-1:0] INIT_NIB_WAKE = 4'h3;
   localparam logic [NIB_W-1:0] INIT_NIB_4BIT = 4'h2;

   function automatic logic [CHAR_W-1:0] init_byte(input logic [1:0] idx);
      logic [CHAR_W-1:0] b;
      case (idx)
         2'd0:    b = 8'h28;
         2'd1:    b = 8'h0E;
         2'd2:    b = 8'h06;
         default: b = 8'h02;
      endcase
      return b;
   endfunction

   typedef enum logic [1:0] {
      TRAIL_ZERO,
      TRAIL_PULSE,
      TRAIL_CLEAR
   } clcd_trail_type;

   typedef struct packed {
      logic              is_init;
      logic              rs;
      logic [CHAR_W-1:0] data;
      clcd_trail_type    trail;
      logic              last;
   } clcd_job_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_us;
      logic [WAIT_W-1:0]  clear_wait_us;
      logic [WAIT_W-1:0]  powerup_wait_us;
      logic [WAIT_W-1:0]  init_gap_us;
   } clcd_cfg_type;

endpackage

### rtl/core/clcd_if.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface channels
// Request, pin-state response and register write channels.
// ----------------------------------------------------------------------------
interface clcd_req_if import clcd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [CHAR_W-1:0]       char_code;
   logic signed [NUM_W-1:0] number;

   modport source (output valid, output cmd, output char_code, output number,
                   input ready);
   modport sink (input valid, input cmd, input char_code, input number,
                 output ready);
endinterface

interface clcd_rsp_if import clcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              reg_select;
   logic              enable;
   logic [NIB_W-1:0]  nibble;
   logic [HOLD_W-1:0] hold_us;
   logic              last;

   modport source (output valid, output reg_select, output enable, output nibble,
                   output hold_us, output last, input ready);
   modport sink (input valid, input reg_select, input enable, input nibble,
                 input hold_us, input last, output ready);
endinterface

interface clcd_csr_if import clcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/clcd_job_fifo.sv
// ----------------------------------------------------------------------------
// Character LCD job queue
// Short first-in first-out queue of byte and init jobs between front and back.
// ----------------------------------------------------------------------------
module clcd_job_fifo import clcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  clcd_job_type push_job,
   input  logic         pop,
   output clcd_job_type head_job,
   output logic         full,
   output logic         empty
);

   clcd_job_type         mem_ff [JOB_FIFO_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;

   function automatic logic [JOB_PTR_W-1:0] next_ptr(input logic [JOB_PTR_W-1:0] p);
      return (p == JOB_PTR_W'(JOB_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == JOB_CNT_W'(JOB_FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("job pushed into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("job popped from an empty queue");

endmodule

### rtl/core/clcd_front.sv
// ----------------------------------------------------------------------------
// Character LCD request front end
// Accepts requests, turns them into byte or init jobs and converts numbers.
// ----------------------------------------------------------------------------
module clcd_front import clcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   clcd_req_if.sink     req_chan,
   input  logic         fifo_full,
   output logic         push,
   output clcd_job_type push_job
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_MINUS,
      F_DIGIT
   } front_state_type;

   front_state_type       state_ff, state_in;
   logic                  init_done_ff, init_done_in;
   logic                  neg_ff, neg_in;
   logic [NUM_W-1:0]      mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CONV_CNT_W-1:0] conv_cnt_ff, conv_cnt_in;
   logic [DIG_IDX_W-1:0]  dig_idx_ff, dig_idx_in;
   logic                  started_ff, started_in;

   logic                  accept;
   logic [NUM_W-1:0]      mag_raw;
   logic [NUM_W-1:0]      mag_sat;
   logic [BCD_W-1:0]      bcd_adj;
   logic [3:0]            digit;
   logic                  want;

   assign req_chan.ready = (state_ff == F_IDLE) && !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign mag_raw        = req_chan.number[NUM_W-1] ? (~req_chan.number + 1'b1)
                                                    : req_chan.number;
   assign mag_sat        = (64'(mag_raw) > NUM_LIMIT) ? NUM_W'(NUM_LIMIT) : mag_raw;
   assign digit          = bcd_ff[dig_idx_ff*4 +: 4];
   assign want           = started_ff || (digit != 4'd0) || (dig_idx_ff == '0);

   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                        : bcd_ff[d*4 +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      init_done_in = init_done_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      conv_cnt_in  = conv_cnt_ff;
      dig_idx_in   = dig_idx_ff;
      started_in   = started_ff;
      push         = 1'b0;
      push_job     = '0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_DATA: begin
                     push     = 1'b1;
                     push_job = '{1'b0, 1'b1, req_chan.char_code, TRAIL_PULSE, 1'b1};
                  end
                  CMD_CLEAR: begin
                     push     = 1'b1;
                     push_job = '{1'b0, 1'b0, CLEAR_CODE, TRAIL_CLEAR, 1'b1};
                  end
                  CMD_STRING: begin
                     push     = 1'b1;
                     push_job = '{1'b0, 1'b1, req_chan.char_code, TRAIL_ZERO, 1'b1};
                  end
                  CMD_INIT: begin
                     if (!init_done_ff) begin
                        push         = 1'b1;
                        push_job     = '{1'b1, 1'b0, '0, TRAIL_ZERO, 1'b1};
                        init_done_in = 1'b1;
                     end
                  end
                  CMD_NUMBER: begin
                     neg_in      = req_chan.number[NUM_W-1];
                     mag_in      = mag_sat;
                     bcd_in      = '0;
                     conv_cnt_in = '0;
                     state_in    = F_CONV;
                  end
                  default: begin
                  end
               endcase
            end
         end
         F_CONV: begin
            bcd_in      = {bcd_adj[BCD_W-2:0], mag_ff[NUM_W-1]};
            mag_in      = {mag_ff[NUM_W-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff + 1'b1;
            if (conv_cnt_ff == CONV_CNT_W'(NUM_W - 1)) begin
               state_in   = neg_ff ? F_MINUS : F_DIGIT;
               dig_idx_in = DIG_IDX_W'(NUM_DIGITS - 1);
               started_in = 1'b0;
            end
         end
         F_MINUS: begin
            if (!fifo_full) begin
               push     = 1'b1;
               push_job = '{1'b0, 1'b1, CHAR_MINUS, TRAIL_ZERO, 1'b0};
               state_in = F_DIGIT;
            end
         end
         F_DIGIT: begin
            if (!want || !fifo_full) begin
               if (want) begin
                  push       = 1'b1;
                  push_job   = '{1'b0, 1'b1, CHAR_ZERO + {4'd0, digit}, TRAIL_ZERO,
                                 dig_idx_ff == '0};
                  started_in = 1'b1;
               end
               if (dig_idx_ff == '0) begin
                  state_in = F_IDLE;
               end else begin
                  dig_idx_in = dig_idx_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         init_done_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_done_ff <= init_done_in;
      end
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      conv_cnt_ff <= conv_cnt_in;
      dig_idx_ff  <= dig_idx_in;
      started_ff  <= started_in;
   end

   a_init_once: assert property (@(posedge clock) disable iff (reset)
      push && push_job.is_init |=> init_done_ff && !$past(init_done_ff))
      else $error("init job queued twice");
   a_init_sticky: assert property (@(posedge clock) disable iff (reset)
      init_done_ff |=> init_done_ff) else $error("init flag dropped");
   a_conv_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == F_CONV |-> conv_cnt_ff < CONV_CNT_W'(NUM_W))
      else $error("conversion counter overran");

endmodule

### rtl/core/clcd_back.sv
// ----------------------------------------------------------------------------
// Character LCD pin sequencer
// Takes jobs from the queue and plays out timed pin states, one per word.
// ----------------------------------------------------------------------------
module clcd_back import clcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  clcd_cfg_type cfg,
   input  clcd_job_type head_job,
   input  logic         fifo_empty,
   output logic         pop,
   clcd_rsp_if.source   rsp_chan
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_POWER,
      B_NIBBLE,
      B_BYTE
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic              init_mode_ff, init_mode_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [2:0]        sub_ff, sub_in;
   logic              rs_ff, rs_in;
   logic [CHAR_W-1:0] byte_ff, byte_in;
   clcd_trail_type    trail_ff, trail_in;
   logic              byte_last_ff, byte_last_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_rs_ff, out_rs_in;
   logic              out_en_ff, out_en_in;
   logic [NIB_W-1:0]  out_nib_ff, out_nib_in;
   logic [HOLD_W-1:0] out_hold_ff, out_hold_in;
   logic              out_last_ff, out_last_in;

   logic              slot_free;
   logic              emit;
   logic              pin_rs, pin_en, pin_last;
   logic [NIB_W-1:0]  pin_nib;
   logic [HOLD_W-1:0] pin_hold;
   logic [HOLD_W-1:0] pulse_hold;
   logic [HOLD_W-1:0] trail_hold;
   logic [HOLD_W-1:0] gap_hold;
   logic [NIB_W-1:0]  init_nib;

   function automatic logic [HOLD_W-1:0] sat_hold(input logic [HOLD_W:0] v);
      return v[HOLD_W] ? '1 : v[HOLD_W-1:0];
   endfunction

   assign slot_free  = !out_valid_ff || rsp_chan.ready;
   assign pop        = (state_ff == B_IDLE) && !fifo_empty;
   assign pulse_hold = HOLD_W'(cfg.pulse_us);
   assign gap_hold   = sat_hold((HOLD_W + 1)'(cfg.pulse_us) + (HOLD_W + 1)'(cfg.init_gap_us));
   assign init_nib   = (cnt_ff == 2'd3) ? INIT_NIB_4BIT : INIT_NIB_WAKE;

   always_comb begin
      case (trail_ff)
         TRAIL_PULSE: trail_hold = pulse_hold;
         TRAIL_CLEAR: trail_hold = cfg.clear_wait_us;
         default:     trail_hold = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      init_mode_in = init_mode_ff;
      cnt_in       = cnt_ff;
      sub_in       = sub_ff;
      rs_in        = rs_ff;
      byte_in      = byte_ff;
      trail_in     = trail_ff;
      byte_last_in = byte_last_ff;
      emit         = 1'b0;
      pin_rs       = 1'b0;
      pin_en       = 1'b0;
      pin_nib      = '0;
      pin_hold     = '0;
      pin_last     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!fifo_empty) begin
               init_mode_in = head_job.is_init;
               rs_in        = head_job.rs;
               byte_in      = head_job.data;
               trail_in     = head_job.trail;
               byte_last_in = head_job.last;
               cnt_in       = '0;
               sub_in       = '0;
               state_in     = head_job.is_init ? B_POWER : B_BYTE;
            end
         end
         B_POWER: begin
            if (slot_free) begin
               emit     = 1'b1;
               pin_hold = cfg.powerup_wait_us;
               state_in = B_NIBBLE;
            end
         end
         B_NIBBLE: begin
            if (slot_free) begin
               emit    = 1'b1;
               pin_nib = init_nib;
               if (sub_ff == 3'd0) begin
                  pin_en   = 1'b1;
                  pin_hold = pulse_hold;
                  sub_in   = 3'd1;
               end else begin
                  pin_hold = (cnt_ff < 2'd2) ? gap_hold : pulse_hold;
                  sub_in   = 3'd0;
                  cnt_in   = cnt_ff + 1'b1;
                  if (cnt_ff == 2'd3) begin
                     state_in     = B_BYTE;
                     cnt_in       = '0;
                     rs_in        = 1'b0;
                     byte_in      = init_byte(2'd0);
                     trail_in     = TRAIL_ZERO;
                     byte_last_in = 1'b0;
                  end
               end
            end
         end
         B_BYTE: begin
            if (slot_free) begin
               emit     = 1'b1;
               pin_rs   = rs_ff;
               pin_hold = pulse_hold;
               sub_in   = sub_ff + 1'b1;
               case (sub_ff)
                  3'd0: begin
                     pin_en  = 1'b1;
                     pin_nib = byte_ff[7:4];
                  end
                  3'd1: begin
                     pin_nib = byte_ff[7:4];
                  end
                  3'd2: begin
                     pin_en  = 1'b1;
                     pin_nib = byte_ff[3:0];
                  end
                  3'd3: begin
                     pin_nib = byte_ff[3:0];
                  end
                  default: begin
                     pin_rs   = 1'b0;
                     pin_nib  = byte_ff[3:0];
                     pin_hold = trail_hold;
                     pin_last = byte_last_ff;
                     sub_in   = '0;
                     if (init_mode_ff && (cnt_ff != 2'd3)) begin
                        cnt_in       = cnt_ff + 1'b1;
                        byte_in      = init_byte(cnt_ff + 1'b1);
                        byte_last_in = (cnt_ff == 2'd2);
                     end else begin
                        state_in = B_IDLE;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_rs_in    = out_rs_ff;
      out_en_in    = out_en_ff;
      out_nib_in   = out_nib_ff;
      out_hold_in  = out_hold_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_rs_in    = pin_rs;
         out_en_in    = pin_en;
         out_nib_in   = pin_nib;
         out_hold_in  = pin_hold;
         out_last_in  = pin_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      init_mode_ff <= init_mode_in;
      cnt_ff       <= cnt_in;
      sub_ff       <= sub_in;
      rs_ff        <= rs_in;
      byte_ff      <= byte_in;
      trail_ff     <= trail_in;
      byte_last_ff <= byte_last_in;
      out_rs_ff    <= out_rs_in;
      out_en_ff    <= out_en_in;
      out_nib_ff   <= out_nib_in;
      out_hold_ff  <= out_hold_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.reg_select = out_rs_ff;
   assign rsp_chan.enable     = out_en_ff;
   assign rsp_chan.nibble     = out_nib_ff;
   assign rsp_chan.hold_us    = out_hold_ff;
   assign rsp_chan.last       = out_last_ff;

   a_last_enable_low: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> !out_en_ff && !out_rs_ff)
      else $error("final pin state with enable or rs high");
   a_nibble_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_NIBBLE |-> sub_ff <= 3'd1 && init_mode_ff)
      else $error("init nibble phase out of range");
   a_byte_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_BYTE |-> sub_ff <= 3'd4) else $error("byte phase out of range");

endmodule

### rtl/core/char_lcd_4bit_interface_top.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface
// Turns display requests into timed pin states for a 4-bit character LCD.
// A request is taken when the front end is idle and the job queue has room. With
// the sequencer idle, a job passes the queue, the sequencer state and the output
// register before its first pin state is valid. A number request is converted to
// decimal, then queued digit by digit without leading zeros; no new request is
// taken meanwhile. Pin states go out while the sink is ready: five per byte, 29
// for the power-up run; the sequencer idles between jobs. Reset is synchronous:
// state and config registers reset, the power-up flag clears, the queue empties.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_top import clcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   clcd_req_if.sink   req_chan,
   clcd_rsp_if.source rsp_chan,
   clcd_csr_if.sink   csr_chan
);

   clcd_cfg_type cfg_ff, cfg_in;
   logic         push;
   clcd_job_type push_job;
   logic         pop;
   clcd_job_type head_job;
   logic         fifo_full;
   logic         fifo_empty;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PULSE:   cfg_in.pulse_us        = csr_chan.data[PULSE_W-1:0];
            CSR_CLEAR:   cfg_in.clear_wait_us   = csr_chan.data[WAIT_W-1:0];
            CSR_POWERUP: cfg_in.powerup_wait_us = csr_chan.data[WAIT_W-1:0];
            CSR_GAP:     cfg_in.init_gap_us     = csr_chan.data[WAIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{PULSE_RESET, CLEAR_RESET, POWERUP_RESET, GAP_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .push_job  (push_job)
   );

   clcd_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   clcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_job   (head_job),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

### sim/char_lcd_4bit_interface_top_tb.sv
// ----------------------------------------------------------------------------
// Character LCD 4-bit interface testbench
// Sends display requests and register writes, predicts every pin-state word
// from its own model of the byte, number and power-up sequences, and compares
// each accepted word field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
module char_lcd_4bit_interface_top_tb;
   import clcd_pkg::*;

   localparam int RANDOM_ITEMS = 330;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 64;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int DIGITS_MAX   = 6;
   localparam int MAG_MAX      = 999999;
   localparam int HOLD_SAT     = 65535;

   localparam logic [CMD_W-1:0]     CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0]     CMD_SPARE_7 = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 8'd4;
   localparam logic [CHAR_W-1:0]    ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]    ASCII_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0]    LCD_CLEAR   = 8'h01;
   localparam logic [NIB_W-1:0]     WAKE_NIB    = 4'h3;
   localparam logic [NIB_W-1:0]     MODE_NIB    = 4'h2;
   localparam logic [31:0]          SETUP_SEQ   = 32'h280E0602;

   typedef struct packed {
      logic [CMD_W-1:0]        cmd;
      logic [CHAR_W-1:0]       ch;
      logic signed [NUM_W-1:0] num;
   } lcd_request_t;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_t;

   typedef struct packed {
      logic              rs;
      logic              en;
      logic [NIB_W-1:0]  nib;
      logic [HOLD_W-1:0] hold;
      logic              last;
   } pin_state_t;

   logic clock = 1'b0;
   logic reset;

   clcd_req_if req_chan();
   clcd_rsp_if rsp_chan();
   clcd_csr_if csr_chan();

   char_lcd_4bit_interface_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   lcd_request_t reqs_to_send[$];
   csr_write_t   csr_writes_due[$];
   pin_state_t   pin_states_due[$];

   logic [PULSE_W-1:0] cfg_pulse;
   logic [WAIT_W-1:0]  cfg_clear;
   logic [WAIT_W-1:0]  cfg_powerup;
   logic [WAIT_W-1:0]  cfg_gap;
   logic               init_seen;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int failures      = 0;
   int cycle_count   = 0;

   lcd_request_t next_req;
   csr_write_t   next_csr;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[char_lcd_4bit_interface_top] ERROR");
         $finish;
      end
   end

   // Prediction of the pin-state words.

   function automatic void add_pin_state(logic rs, logic en, logic [NIB_W-1:0] nib,
                                         int unsigned hold);
      pin_state_t s;
      s.rs   = rs;
      s.en   = en;
      s.nib  = nib;
      s.hold = (hold > HOLD_SAT) ? HOLD_SAT[HOLD_W-1:0] : hold[HOLD_W-1:0];
      s.last = 1'b0;
      pin_states_due.push_back(s);
   endfunction

   function automatic void add_byte(logic rs, logic [CHAR_W-1:0] b, int unsigned trail);
      add_pin_state(rs, 1'b1, b[7:4], 32'(cfg_pulse));
      add_pin_state(rs, 1'b0, b[7:4], 32'(cfg_pulse));
      add_pin_state(rs, 1'b1, b[3:0], 32'(cfg_pulse));
      add_pin_state(rs, 1'b0, b[3:0], 32'(cfg_pulse));
      add_pin_state(1'b0, 1'b0, b[3:0], trail);
   endfunction

   function automatic void add_number(logic signed [NUM_W-1:0] num);
      int value;
      int mag;
      int k;
      logic [3:0] digs [DIGITS_MAX];
      value = int'(num);
      mag = (value < 0) ? -value : value;
      if (mag > MAG_MAX) mag = MAG_MAX;
      if (mag == 0) begin
         add_byte(1'b1, ASCII_ZERO, 0);
         return;
      end
      if (value < 0) add_byte(1'b1, ASCII_MINUS, 0);
      k = 0;
      while (mag > 0) begin
         digs[k] = 4'(mag % 10);
         mag = mag / 10;
         k++;
      end
      while (k > 0) begin
         k--;
         add_byte(1'b1, ASCII_ZERO + {4'd0, digs[k]}, 0);
      end
   endfunction

   function automatic void predict_request(lcd_request_t r);
      int first;
      pin_state_t tail;
      first = pin_states_due.size();
      case (r.cmd)
         CMD_DATA: begin
            add_byte(1'b1, r.ch, 32'(cfg_pulse));
         end
         CMD_CLEAR: begin
            add_byte(1'b0, LCD_CLEAR, 32'(cfg_clear));
         end
         CMD_NUMBER: begin
            add_number(r.num);
         end
         CMD_INIT: begin
            if (!init_seen) begin
               add_pin_state(1'b0, 1'b0, 4'h0, 32'(cfg_powerup));
               for (int i = 0; i < 4; i++) begin
                  add_pin_state(1'b0, 1'b1, (i < 3) ? WAKE_NIB : MODE_NIB,
                                32'(cfg_pulse));
                  add_pin_state(1'b0, 1'b0, (i < 3) ? WAKE_NIB : MODE_NIB,
                                32'(cfg_pulse) + ((i < 2) ? 32'(cfg_gap) : 32'd0));
               end
               for (int i = 0; i < 4; i++) begin
                  add_byte(1'b0, SETUP_SEQ[31-8*i -: 8], 0);
               end
               init_seen = 1'b1;
            end
         end
         CMD_STRING: begin
            add_byte(1'b1, r.ch, 0);
         end
         default: begin
         end
      endcase
      if (pin_states_due.size() > first) begin
         tail = pin_states_due.pop_back();
         tail.last = 1'b1;
         pin_states_due.push_back(tail);
      end
   endfunction

   function automatic void apply_write(logic [CSR_IDX_W-1:0] idx,
                                       logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PULSE:   cfg_pulse   = data[PULSE_W-1:0];
         CSR_CLEAR:   cfg_clear   = data;
         CSR_POWERUP: cfg_powerup = data;
         CSR_GAP:     cfg_gap     = data;
         default: begin
         end
      endcase
   endfunction

   // Checking of the pin-state words.

   function automatic void compare_field(string name, logic [HOLD_W-1:0] want,
                                         logic [HOLD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_word();
      pin_state_t want;
      if (pin_states_due.size() == 0) begin
         $error("unexpected word: rs %0d enable %0d nibble %0h hold %0d last %0d",
                rsp_chan.reg_select, rsp_chan.enable, rsp_chan.nibble,
                rsp_chan.hold_us, rsp_chan.last);
         failures++;
         return;
      end
      want = pin_states_due.pop_front();
      compare_field("reg_select", HOLD_W'(want.rs), HOLD_W'(rsp_chan.reg_select));
      compare_field("enable", HOLD_W'(want.en), HOLD_W'(rsp_chan.enable));
      compare_field("nibble", HOLD_W'(want.nib), HOLD_W'(rsp_chan.nibble));
      compare_field("hold_us", want.hold, rsp_chan.hold_us);
      compare_field("last", HOLD_W'(want.last), HOLD_W'(rsp_chan.last));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_pulse   = PULSE_RESET;
         cfg_clear   = CLEAR_RESET;
         cfg_powerup = POWERUP_RESET;
         cfg_gap     = GAP_RESET;
         init_seen   = 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) apply_write(csr_chan.index, csr_chan.data);
         if (req_chan.valid && req_chan.ready) begin
            predict_request('{req_chan.cmd, req_chan.char_code, req_chan.number});
         end
         if (rsp_chan.valid && rsp_chan.ready) check_word();
      end
   end

   // Drivers.

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (reqs_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = reqs_to_send.pop_front();
            req_chan.valid     <= 1'b1;
            req_chan.cmd       <= next_req.cmd;
            req_chan.char_code <= next_req.ch;
            req_chan.number    <= next_req.num;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         csr_chan.valid <= 1'b0;
      end else if (!csr_chan.valid || csr_chan.ready) begin
         if (csr_writes_due.size() != 0) begin
            next_csr = csr_writes_due.pop_front();
            csr_chan.valid <= 1'b1;
            csr_chan.index <= next_csr.idx;
            csr_chan.data  <= next_csr.data;
         end else begin
            csr_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Stimulus.

   task automatic queue_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                logic signed [NUM_W-1:0] num);
      reqs_to_send.push_back('{cmd, ch, num});
   endtask

   task automatic queue_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_writes_due.push_back('{idx, data});
   endtask

   task automatic wait_drained();
      while (reqs_to_send.size() != 0 || req_chan.valid || csr_writes_due.size() != 0 ||
             csr_chan.valid || pin_states_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [NUM_W-1:0] random_number();
      int sel;
      int digits;
      int mag;
      sel = $urandom_range(0, 9);
      if (sel <= 2) return NUM_W'($urandom);
      if (sel == 3) begin
         case ($urandom_range(0, 6))
            0:       return 999999;
            1:       return -999999;
            2:       return 1048575;
            3:       return -1048576;
            4:       return 1000000;
            5:       return -1;
            default: return 0;
         endcase
      end
      digits = $urandom_range(1, DIGITS_MAX);
      mag = $urandom_range(0, 10 ** digits - 1);
      return $urandom_range(0, 1) ? NUM_W'(-mag) : NUM_W'(mag);
   endfunction

   function automatic lcd_request_t random_request();
      lcd_request_t r;
      int sel;
      r.ch  = CHAR_W'($urandom_range(0, 255));
      r.num = random_number();
      sel = $urandom_range(0, 99);
      if (sel < 30)      r.cmd = CMD_DATA;
      else if (sel < 52) r.cmd = CMD_STRING;
      else if (sel < 62) r.cmd = CMD_CLEAR;
      else if (sel < 92) r.cmd = CMD_NUMBER;
      else if (sel < 95) r.cmd = CMD_INIT;
      else begin
         case ($urandom_range(0, 2))
            0:       r.cmd = CMD_SPARE_5;
            1:       r.cmd = CMD_SPARE_6;
            default: r.cmd = CMD_SPARE_7;
         endcase
      end
      return r;
   endfunction

   initial begin
      lcd_request_t r;
      int counted;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.cmd       = CMD_DATA;
      req_chan.char_code = 8'h00;
      req_chan.number    = 0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_PULSE;
      csr_chan.data      = 16'h0000;
      rsp_chan.ready     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Requests before the power-up sequence, with the reset register values.
      queue_request(CMD_DATA, 8'h00, 0);
      queue_request(CMD_DATA, 8'hFF, -1);
      queue_request(CMD_STRING, 8'hA5, 0);
      queue_request(CMD_STRING, 8'h5A, 0);
      queue_request(CMD_CLEAR, 8'h00, 0);
      queue_request(CMD_NUMBER, 8'h00, 0);
      queue_request(CMD_NUMBER, 8'h00, 1);
      queue_request(CMD_NUMBER, 8'h00, -1);
      queue_request(CMD_NUMBER, 8'h00, 999999);
      queue_request(CMD_NUMBER, 8'h00, -999999);
      queue_request(CMD_NUMBER, 8'h00, 1000000);
      queue_request(CMD_NUMBER, 8'hFF, 1048575);
      queue_request(CMD_NUMBER, 8'h00, -1048576);
      queue_request(CMD_SPARE_5, 8'h12, 0);
      queue_request(CMD_SPARE_6, 8'h34, 0);
      queue_request(CMD_SPARE_7, 8'h56, 0);
      wait_drained();

      // The power-up run with every wait at its top value, so long holds saturate.
      queue_write(CSR_PULSE, 16'h00FF);
      queue_write(CSR_CLEAR, 16'hFFFF);
      queue_write(CSR_POWERUP, 16'hFFFF);
      queue_write(CSR_GAP, 16'hFFFF);
      wait_drained();
      queue_request(CMD_INIT, 8'h00, 0);
      queue_request(CMD_INIT, 8'h00, 0);
      queue_request(CMD_DATA, 8'h41, 0);
      queue_request(CMD_CLEAR, 8'h00, 0);
      queue_request(CMD_NUMBER, 8'h00, -123456);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 88;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 88;
            end
            default: begin
               send_idle_pct = 26;
               stall_pct     = 26;
            end
         endcase
         if (phase == 0) begin
            queue_write(CSR_PULSE, 16'h0000);
            queue_write(CSR_CLEAR, 16'h0000);
            queue_write(CSR_POWERUP, 16'h0000);
            queue_write(CSR_GAP, 16'h0000);
         end else if (phase == 1) begin
            queue_write(CSR_PULSE, 16'h00FF);
            queue_write(CSR_CLEAR, 16'hFFFF);
            queue_write(CSR_POWERUP, 16'hFFFF);
            queue_write(CSR_GAP, 16'd60000);
         end else begin
            queue_write(CSR_PULSE, CSR_DATA_W'($urandom_range(0, 65535)));
            queue_write(CSR_CLEAR, CSR_DATA_W'($urandom_range(0, 65535)));
            queue_write(CSR_POWERUP, CSR_DATA_W'($urandom_range(0, 65535)));
            queue_write(CSR_GAP, CSR_DATA_W'($urandom_range(0, 65535)));
            if (phase == 2) queue_write(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 65535)));
         end
         wait_drained();
         counted = 0;
         while (counted < RANDOM_ITEMS / PHASES) begin
            r = random_request();
            reqs_to_send.push_back(r);
            counted++;
         end
         wait_drained();
      end

      if (failures == 0) begin
         $display("[char_lcd_4bit_interface_top] OK");
      end else begin
         $display("[char_lcd_4bit_interface_top] ERROR");
      end
      $finish;
   end

endmodule
